// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in every cycle in which ante holds
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// expr must never be seen at a clock edge
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`endif

// ===== design/nnis_pkg.sv =====
package nnis_pkg;

	localparam int MAX_SOURCE_WIDTH  = 512;
	localparam int MAX_SOURCE_HEIGHT = 512;
	localparam int PIXEL_BITS        = 32;

	// fixed field widths
	localparam int COORD_W    = 12;
	localparam int SRC_SIZE_W = 10;
	localparam int TGT_SIZE_W = 13;
	localparam int PIX_W      = 32;
	localparam int MAP_W      = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam int MAX_SIDE    = (MAX_SOURCE_WIDTH > MAX_SOURCE_HEIGHT) ?
		MAX_SOURCE_WIDTH : MAX_SOURCE_HEIGHT;
	// one quotient bit per divider stage
	localparam int DIV_STAGES  = $clog2(MAX_SIDE);
	localparam int DIV_W       = TGT_SIZE_W + DIV_STAGES;
	localparam int PROD_W      = COORD_W + SRC_SIZE_W;
	localparam int STORE_DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int FIFO_DEPTH  = 4;

	localparam logic [SRC_SIZE_W-1:0] RST_SRC_W = SRC_SIZE_W'(512);
	localparam logic [SRC_SIZE_W-1:0] RST_SRC_H = SRC_SIZE_W'(512);
	localparam logic [TGT_SIZE_W-1:0] RST_TGT_W = TGT_SIZE_W'(128);
	localparam logic [TGT_SIZE_W-1:0] RST_TGT_H = TGT_SIZE_W'(128);

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_WIDTH  = 2'd0,
		REG_SOURCE_HEIGHT = 2'd1,
		REG_TARGET_WIDTH  = 2'd2,
		REG_TARGET_HEIGHT = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_LOAD,
		KIND_SAMPLE,
		KIND_ERROR
	} kind_t;

	typedef struct packed {
		logic               opcode;
		logic [COORD_W-1:0] coord_x;
		logic [COORD_W-1:0] coord_y;
		logic [PIX_W-1:0]   pixel_in;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic [MAP_W-1:0] mapped_x;
		logic [MAP_W-1:0] mapped_y;
		logic             range_error;
	} out_item_t;

	typedef struct packed {
		logic [SRC_SIZE_W-1:0] src_w;
		logic [SRC_SIZE_W-1:0] src_h;
		logic [TGT_SIZE_W-1:0] tgt_w;
		logic [TGT_SIZE_W-1:0] tgt_h;
	} cfg_t;

	// queue entry: for a sample num_* are dividends, for a load the source coords
	typedef struct packed {
		kind_t                 kind;
		logic [DIV_W-1:0]      num_x;
		logic [DIV_W-1:0]      num_y;
		logic [PIXEL_BITS-1:0] pixel;
	} entry_t;

	function automatic logic [SRC_SIZE_W-1:0] clamp_size(
		input logic [SRC_SIZE_W-1:0] v,
		input int unsigned           max_v
	);
		logic [SRC_SIZE_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = SRC_SIZE_W'(1);
		end else if (32'(v) > max_v) begin
			r = SRC_SIZE_W'(max_v);
		end
		return r;
	endfunction

endpackage

// ===== design/nnis_front.sv =====
module nnis_front (
	input  logic              in_valid,
	output logic              in_ready,
	input  nnis_pkg::in_item_t in_data,
	input  nnis_pkg::cfg_t    cfg,
	input  logic              q_full,
	output logic              q_push,
	output nnis_pkg::entry_t  q_entry
);
	import nnis_pkg::*;

	logic [SRC_SIZE_W-1:0] sw;
	logic [SRC_SIZE_W-1:0] sh;
	logic                  is_sample;
	logic                  load_ok;
	logic                  off_target;

	always_comb begin
		sw = clamp_size(cfg.src_w, MAX_SOURCE_WIDTH);
		sh = clamp_size(cfg.src_h, MAX_SOURCE_HEIGHT);
		is_sample = (in_data.opcode == OP_SAMPLE);
		load_ok = (in_data.coord_x < COORD_W'(sw)) && (in_data.coord_y < COORD_W'(sh));
		off_target = (TGT_SIZE_W'(in_data.coord_x) >= cfg.tgt_w) ||
			(TGT_SIZE_W'(in_data.coord_y) >= cfg.tgt_h);

		q_entry.pixel = PIXEL_BITS'(in_data.pixel_in);
		if (!is_sample) begin
			q_entry.kind  = KIND_LOAD;
			q_entry.num_x = DIV_W'(in_data.coord_x);
			q_entry.num_y = DIV_W'(in_data.coord_y);
		end else if (off_target) begin
			q_entry.kind  = KIND_ERROR;
			q_entry.num_x = '0;
			q_entry.num_y = '0;
		end else begin
			q_entry.kind  = KIND_SAMPLE;
			q_entry.num_x = DIV_W'(PROD_W'(in_data.coord_x) * PROD_W'(sw));
			q_entry.num_y = DIV_W'(PROD_W'(in_data.coord_y) * PROD_W'(sh));
		end

		in_ready = !q_full;
		// loads outside the source frame are dropped here
		q_push = in_valid && !q_full && (is_sample || load_ok);
	end

endmodule

// ===== design/nnis_fifo.sv =====
module nnis_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  nnis_pkg::entry_t wdata,
	input  logic             pop,
	output nnis_pkg::entry_t rdata,
	output logic             full,
	output logic             empty
);
	import nnis_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	entry_t           slot_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== design/nnis_back.sv =====
module nnis_back (
	input  logic                clk,
	input  logic                arst_n,
	input  nnis_pkg::cfg_t      cfg,
	input  nnis_pkg::entry_t    q_head,
	input  logic                q_empty,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output nnis_pkg::out_item_t out_data
);
	import nnis_pkg::*;

	typedef struct packed {
		kind_t                 kind;
		logic [DIV_W-1:0]      rem_x;
		logic [DIV_W-1:0]      rem_y;
		logic [DIV_STAGES-1:0] q_x;
		logic [DIV_STAGES-1:0] q_y;
		logic [PIXEL_BITS-1:0] pixel;
	} stage_t;

	stage_t                div_ent_s [DIV_STAGES];
	logic                  div_vld_s [DIV_STAGES];
	stage_t                nxt_ent   [DIV_STAGES];
	logic                  nxt_vld   [DIV_STAGES];
	stage_t                head_st;
	stage_t                last;
	logic                  en;
	logic [ADDR_W-1:0]     addr;

	logic [PIXEL_BITS-1:0] store [STORE_DEPTH];
	logic [PIXEL_BITS-1:0] rdata_q;
	logic [DIV_STAGES-1:0] mx_q;
	logic [DIV_STAGES-1:0] my_q;
	logic                  err_q;
	logic                  out_valid_q;

	// whole back end moves together; frozen only while a result waits
	assign en    = !out_valid_q || out_ready;
	assign q_pop = en && !q_empty;
	assign last  = div_ent_s[DIV_STAGES-1];
	assign addr  = ADDR_W'(last.q_y) * ADDR_W'(MAX_SOURCE_WIDTH) + ADDR_W'(last.q_x);

	always_comb begin
		head_st.kind  = q_head.kind;
		head_st.rem_x = q_head.num_x;
		head_st.rem_y = q_head.num_y;
		head_st.pixel = q_head.pixel;
		// a load carries its store coordinates in the quotient fields
		head_st.q_x = (q_head.kind == KIND_LOAD) ? q_head.num_x[DIV_STAGES-1:0] : '0;
		head_st.q_y = (q_head.kind == KIND_LOAD) ? q_head.num_y[DIV_STAGES-1:0] : '0;
	end

	// restoring division, one quotient bit per stage, MSB first
	always_comb begin
		stage_t           src;
		logic [DIV_W-1:0] dx;
		logic [DIV_W-1:0] dy;
		int               b;
		for (int i = 0; i < DIV_STAGES; i++) begin
			src        = (i == 0) ? head_st : div_ent_s[(i == 0) ? 0 : i - 1];
			nxt_vld[i] = (i == 0) ? !q_empty : div_vld_s[(i == 0) ? 0 : i - 1];
			b          = DIV_STAGES - 1 - i;
			dx         = DIV_W'(cfg.tgt_w) << b;
			dy         = DIV_W'(cfg.tgt_h) << b;
			nxt_ent[i] = src;
			if (src.kind == KIND_SAMPLE) begin
				if (src.rem_x >= dx) begin
					nxt_ent[i].rem_x  = src.rem_x - dx;
					nxt_ent[i].q_x[b] = 1'b1;
				end
				if (src.rem_y >= dy) begin
					nxt_ent[i].rem_y  = src.rem_y - dy;
					nxt_ent[i].q_y[b] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_STAGES; i++) begin
				div_vld_s[i] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (en) begin
			div_vld_s   <= nxt_vld;
			out_valid_q <= div_vld_s[DIV_STAGES-1] && (last.kind != KIND_LOAD);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_ent_s <= nxt_ent;
			mx_q      <= last.q_x;
			my_q      <= last.q_y;
			err_q     <= (last.kind == KIND_ERROR);
		end
	end

	// single-port frame store: loads and samples hit it in arrival order
	always_ff @(posedge clk) begin
		if (en && div_vld_s[DIV_STAGES-1]) begin
			if (last.kind == KIND_LOAD) begin
				store[addr] <= last.pixel;
			end else begin
				rdata_q <= store[addr];
			end
		end
	end

	assign out_valid            = out_valid_q;
	assign out_data.pixel_out   = err_q ? '0 : PIX_W'(rdata_q);
	assign out_data.mapped_x    = MAP_W'(mx_q);
	assign out_data.mapped_y    = MAP_W'(my_q);
	assign out_data.range_error = err_q;

endmodule

// ===== design/nearest_neighbor_image_scaler.sv =====
// Nearest-neighbor scaler over a 512x512 frame store. A load beat writes one
// pixel at a source coordinate (loads outside the configured source size are
// dropped); a sample beat maps a destination coordinate to source
// (x*src_w/tgt_w, y*src_h/tgt_h), rounded down, and returns that pixel with
// the chosen coordinates, or range_error with zeros when the coordinate lies
// outside the target size. One beat per clock is sustained while out_ready does
// not stall the back end. On its way the front classifies and multiplies
// a sample into a 4-entry queue, then 9 divider stages (one quotient bit
// each, the first working straight off the queue head) and a registered read
// of the single frame store port, which every load and sample passes through in
// order. The store is not cleared at reset: sampling a pixel that was never
// loaded returns an undefined value.
`include "assert_macros.svh"

module nearest_neighbor_image_scaler (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  nnis_pkg::in_item_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output nnis_pkg::out_item_t                  out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [nnis_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [nnis_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import nnis_pkg::*;

	cfg_t   cfg_q;
	logic   q_full;
	logic   q_empty;
	logic   q_push;
	logic   q_pop;
	entry_t q_entry;
	entry_t q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_w <= RST_SRC_W;
			cfg_q.src_h <= RST_SRC_H;
			cfg_q.tgt_w <= RST_TGT_W;
			cfg_q.tgt_h <= RST_TGT_H;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SOURCE_WIDTH:  cfg_q.src_w <= SRC_SIZE_W'(cfg_data);
				REG_SOURCE_HEIGHT: cfg_q.src_h <= SRC_SIZE_W'(cfg_data);
				REG_TARGET_WIDTH:  cfg_q.tgt_w <= TGT_SIZE_W'(cfg_data);
				REG_TARGET_HEIGHT: cfg_q.tgt_h <= TGT_SIZE_W'(cfg_data);
				default: ;
			endcase
		end
	end

	nnis_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	nnis_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_entry),
		.pop    (q_pop),
		.rdata  (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	nnis_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_head    (q_head),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	`ASSERT_IMPLIES(a_err_zero, clk, arst_n, out_valid && out_data.range_error, (out_data.pixel_out == '0) && (out_data.mapped_x == '0) && (out_data.mapped_y == '0))
	`ASSERT_IMPLIES(a_map_x_in_src, clk, arst_n, out_valid && !out_data.range_error, (out_data.mapped_x == '0) || (SRC_SIZE_W'(out_data.mapped_x) < cfg_q.src_w))
	`ASSERT_IMPLIES(a_map_y_in_src, clk, arst_n, out_valid && !out_data.range_error, (out_data.mapped_y == '0) || (SRC_SIZE_W'(out_data.mapped_y) < cfg_q.src_h))
	`ASSERT_NEVER(a_pop_empty, clk, arst_n, q_pop && q_empty)

endmodule
